// ===== sv/des_pkg.sv =====
`default_nettype none
package des_pkg;

  localparam int MAX_HITS = 16;
  localparam int CNT_W = $clog2(MAX_HITS + 1);

  localparam int ENERGY_W = 24;
  localparam int HIT_E_W = 20;
  localparam int Z_W = 16;
  localparam int DEPTH_MAX_W = 16;
  localparam int HALF_W = 15;
  localparam int DEPTH_SUM_W = 22;
  localparam int D_W = 18;
  localparam int DS_W = DEPTH_SUM_W + 1;
  localparam int BAND_W = 32;
  localparam int PROD_W = DEPTH_MAX_W + CNT_W;
  localparam int CMP_W = (PROD_W > DEPTH_SUM_W - 1) ? PROD_W : DEPTH_SUM_W - 1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int SQ_DEPTH = 2;
  localparam int SQ_AW = $clog2(SQ_DEPTH);
  localparam int SQ_CW = $clog2(SQ_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MAX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_BAD_CAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_DEPTH_FLAG = 3'd5;

  localparam logic [2:0] R_KEEP = 3'd0;
  localparam logic [2:0] R_EMPTY = 3'd1;
  localparam logic [2:0] R_PATTERN = 3'd2;
  localparam logic [2:0] R_ENERGY = 3'd3;
  localparam logic [2:0] R_DEPTH = 3'd4;
  localparam logic [2:0] R_BAD_CAL = 3'd5;
  localparam logic [2:0] R_DEPTH_FLAG = 3'd6;
  localparam logic [2:0] R_TOO_MANY = 3'd7;

  localparam logic [ENERGY_W-1:0] ENERGY_MIN_RST = 24'd3000;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX_RST = 24'd80000;
  localparam logic [DEPTH_MAX_W-1:0] DEPTH_MAX_RST = 16'd40000;
  localparam logic [HALF_W-1:0] HALF_HEIGHT_RST = 15'd1000;

  localparam logic [ENERGY_W-1:0] BAND_5KEV = 24'd5000;
  localparam logic [ENERGY_W-1:0] BAND_10KEV = 24'd10000;
  localparam logic [ENERGY_W-1:0] BAND_20KEV = 24'd20000;
  localparam logic [ENERGY_W-1:0] BAND_60KEV = 24'd60000;

  localparam logic [DEPTH_SUM_W-1:0] DEPTH_HI = {1'b0, {(DEPTH_SUM_W-1){1'b1}}};
  localparam logic [DEPTH_SUM_W-1:0] DEPTH_LO = {1'b1, {(DEPTH_SUM_W-1){1'b0}}};
  localparam logic [BAND_W-1:0] BAND_SAT = {BAND_W{1'b1}};

  typedef struct packed {
    logic [ENERGY_W-1:0] energy_min_ev;
    logic [ENERGY_W-1:0] energy_max_ev;
    logic [DEPTH_MAX_W-1:0] depth_max_um;
    logic [HALF_W-1:0] half_height_um;
    logic cut_bad_depth_cal;
    logic cut_depth_flag;
  } cfg_t;

  typedef struct packed {
    logic is_empty;
    logic [ENERGY_W-1:0] energy_sum;
    logic [DEPTH_SUM_W-1:0] depth_sum;
    logic [CNT_W-1:0] hit_count;
    logic pattern_mismatch;
    logic any_bad_cal;
    logic any_depth_mark;
    logic too_many_hits;
  } summary_t;

endpackage
`default_nettype wire

// ===== sv/des_front.sv =====
`default_nettype none
module des_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  des_pkg::cfg_t                        cfg,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 empty_event,
  input  logic                                 telescope_id,
  input  logic [3:0]                           detector_id,
  input  logic [des_pkg::HIT_E_W-1:0]          hit_energy_ev,
  input  logic signed [des_pkg::Z_W-1:0]       hit_z_um,
  input  logic                                 bad_depth_cal,
  input  logic                                 depth_cut_mark,
  input  logic                                 last_hit,
  input  logic                                 q_full,
  output logic                                 sum_push,
  output des_pkg::summary_t                    sum_data
);

  logic                                 first_telescope;
  logic [3:0]                           first_detector;
  logic [des_pkg::CNT_W-1:0]            hit_count;
  logic [des_pkg::ENERGY_W-1:0]         energy_sum;
  logic signed [des_pkg::DEPTH_SUM_W-1:0] depth_sum;
  logic                                 pattern_mismatch;
  logic                                 any_bad_cal;
  logic                                 any_depth_mark;
  logic                                 too_many_hits;

  logic                                 first_telescope_next;
  logic [3:0]                           first_detector_next;
  logic [des_pkg::CNT_W-1:0]            hit_count_next;
  logic [des_pkg::ENERGY_W-1:0]         energy_sum_next;
  logic signed [des_pkg::DEPTH_SUM_W-1:0] depth_sum_next;
  logic                                 pattern_mismatch_next;
  logic                                 too_many_hits_next;

  logic                                 accept;
  logic                                 first_hit;
  logic                                 at_max;
  logic [des_pkg::ENERGY_W:0]           e_wide;
  logic signed [des_pkg::D_W-1:0]       d_hit;
  logic signed [des_pkg::DS_W-1:0]      ds_wide;

  assign full = q_full;
  assign accept = push & ~q_full;
  assign sum_push = accept & (empty_event | last_hit);

  always_comb begin
    first_hit = (hit_count == '0) && !too_many_hits;
    at_max = (hit_count == des_pkg::CNT_W'(des_pkg::MAX_HITS));

    first_telescope_next = first_hit ? telescope_id : first_telescope;
    first_detector_next = first_hit ? detector_id : first_detector;
    pattern_mismatch_next = pattern_mismatch |
        (!first_hit && (telescope_id != first_telescope || detector_id != first_detector));
    too_many_hits_next = too_many_hits | at_max;
    hit_count_next = at_max ? hit_count : hit_count + des_pkg::CNT_W'(1);

    e_wide = {1'b0, energy_sum} + (des_pkg::ENERGY_W+1)'(hit_energy_ev);
    energy_sum_next = e_wide[des_pkg::ENERGY_W] ? {des_pkg::ENERGY_W{1'b1}}
                                                : e_wide[des_pkg::ENERGY_W-1:0];

    // depth of this hit below the reference plane
    d_hit = des_pkg::D_W'({1'b0, cfg.half_height_um}) - des_pkg::D_W'(hit_z_um);
    ds_wide = des_pkg::DS_W'(depth_sum) + des_pkg::DS_W'(d_hit);
    if (!ds_wide[des_pkg::DS_W-1] && ds_wide[des_pkg::DS_W-2]) begin
      depth_sum_next = des_pkg::DEPTH_HI;
    end else if (ds_wide[des_pkg::DS_W-1] && !ds_wide[des_pkg::DS_W-2]) begin
      depth_sum_next = des_pkg::DEPTH_LO;
    end else begin
      depth_sum_next = ds_wide[des_pkg::DS_W-2:0];
    end

    sum_data.is_empty = empty_event;
    sum_data.energy_sum = energy_sum_next;
    sum_data.depth_sum = depth_sum_next;
    sum_data.hit_count = hit_count_next;
    sum_data.pattern_mismatch = pattern_mismatch_next;
    sum_data.any_bad_cal = any_bad_cal | bad_depth_cal;
    sum_data.any_depth_mark = any_depth_mark | depth_cut_mark;
    sum_data.too_many_hits = too_many_hits_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && (empty_event || last_hit))) begin
      first_telescope <= 1'b0;
      first_detector <= '0;
      hit_count <= '0;
      energy_sum <= '0;
      depth_sum <= '0;
      pattern_mismatch <= 1'b0;
      any_bad_cal <= 1'b0;
      any_depth_mark <= 1'b0;
      too_many_hits <= 1'b0;
    end else if (accept) begin
      first_telescope <= first_telescope_next;
      first_detector <= first_detector_next;
      hit_count <= hit_count_next;
      energy_sum <= energy_sum_next;
      depth_sum <= depth_sum_next;
      pattern_mismatch <= pattern_mismatch_next;
      any_bad_cal <= any_bad_cal | bad_depth_cal;
      any_depth_mark <= any_depth_mark | depth_cut_mark;
      too_many_hits <= too_many_hits_next;
    end
  end

  a_clear_after_push: assert property (@(posedge clk) disable iff (rst)
    sum_push |=> (hit_count == '0) && !too_many_hits && (energy_sum == '0))
    else $error("event state not cleared after summary push");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    hit_count <= des_pkg::CNT_W'(des_pkg::MAX_HITS))
    else $error("hit count beyond limit");

  a_too_many_at_max: assert property (@(posedge clk) disable iff (rst)
    too_many_hits |-> hit_count == des_pkg::CNT_W'(des_pkg::MAX_HITS))
    else $error("overflow flag without full hit count");

endmodule
`default_nettype wire

// ===== sv/des_queue.sv =====
`default_nettype none
module des_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  des_pkg::summary_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              valid,
  output des_pkg::summary_t rd_data
);

  des_pkg::summary_t            mem [des_pkg::SQ_DEPTH];
  logic [des_pkg::SQ_AW-1:0]    wptr;
  logic [des_pkg::SQ_AW-1:0]    rptr;
  logic [des_pkg::SQ_CW-1:0]    count;
  logic                         do_wr;
  logic                         do_rd;

  assign full = (count == des_pkg::SQ_CW'(des_pkg::SQ_DEPTH));
  assign valid = (count != '0);
  assign do_wr = wr_en & ~full;
  assign do_rd = rd_en & valid;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == des_pkg::SQ_AW'(des_pkg::SQ_DEPTH - 1)) ? '0
                                                                 : wptr + des_pkg::SQ_AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == des_pkg::SQ_AW'(des_pkg::SQ_DEPTH - 1)) ? '0
                                                                 : rptr + des_pkg::SQ_AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + des_pkg::SQ_CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - des_pkg::SQ_CW'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= des_pkg::SQ_CW'(des_pkg::SQ_DEPTH))
    else $error("summary queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("write into full summary queue");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wptr == rptr))
    else $error("queue pointers differ while empty");

endmodule
`default_nettype wire

// ===== sv/des_back.sv =====
`default_nettype none
module des_back (
  input  logic                          clk,
  input  logic                          rst,
  input  des_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  input  des_pkg::summary_t             q_data,
  output logic                          q_rd,
  output logic                          empty,
  input  logic                          pop,
  output logic                          event_cut,
  output logic [2:0]                    cut_reason,
  output logic [des_pkg::ENERGY_W-1:0]  total_energy_ev,
  output logic [des_pkg::BAND_W-1:0]    band_low_count,
  output logic [des_pkg::BAND_W-1:0]    band_mid_count,
  output logic [des_pkg::BAND_W-1:0]    band_high_count
);

  logic                          out_valid;
  logic                          out_cut;
  logic [2:0]                    out_reason;
  logic [des_pkg::ENERGY_W-1:0]  out_energy;
  logic [des_pkg::BAND_W-1:0]    band_low;
  logic [des_pkg::BAND_W-1:0]    band_mid;
  logic [des_pkg::BAND_W-1:0]    band_high;

  logic                          take;
  logic [des_pkg::PROD_W-1:0]    depth_limit;
  logic                          depth_bad;
  logic                          energy_bad;
  logic                          in_low;
  logic                          in_mid;
  logic                          in_high;
  logic [2:0]                    reason;

  assign take = q_valid & (~out_valid | pop);
  assign q_rd = take;
  assign empty = ~out_valid;
  assign event_cut = out_cut;
  assign cut_reason = out_reason;
  assign total_energy_ev = out_energy;
  assign band_low_count = band_low;
  assign band_mid_count = band_mid;
  assign band_high_count = band_high;

  always_comb begin
    // average depth test as sum > limit * hits; a negative sum also fails
    depth_limit = des_pkg::PROD_W'(cfg.depth_max_um) * des_pkg::PROD_W'(q_data.hit_count);
    depth_bad = q_data.depth_sum[des_pkg::DEPTH_SUM_W-1] |
        (des_pkg::CMP_W'(q_data.depth_sum[des_pkg::DEPTH_SUM_W-2:0]) >
         des_pkg::CMP_W'(depth_limit));
    energy_bad = (q_data.energy_sum > cfg.energy_max_ev) ||
                 (q_data.energy_sum < cfg.energy_min_ev);

    in_low = (q_data.energy_sum >= des_pkg::BAND_5KEV) &&
             (q_data.energy_sum < des_pkg::BAND_10KEV);
    in_mid = (q_data.energy_sum >= des_pkg::BAND_10KEV) &&
             (q_data.energy_sum < des_pkg::BAND_20KEV);
    in_high = (q_data.energy_sum >= des_pkg::BAND_20KEV) &&
              (q_data.energy_sum <= des_pkg::BAND_60KEV);

    if (q_data.is_empty) begin
      reason = des_pkg::R_EMPTY;
    end else if (q_data.too_many_hits) begin
      reason = des_pkg::R_TOO_MANY;
    end else if (q_data.pattern_mismatch) begin
      reason = des_pkg::R_PATTERN;
    end else if (energy_bad) begin
      reason = des_pkg::R_ENERGY;
    end else if (depth_bad) begin
      reason = des_pkg::R_DEPTH;
    end else if (q_data.any_bad_cal && cfg.cut_bad_depth_cal) begin
      reason = des_pkg::R_BAD_CAL;
    end else if (q_data.any_depth_mark && cfg.cut_depth_flag) begin
      reason = des_pkg::R_DEPTH_FLAG;
    end else begin
      reason = des_pkg::R_KEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_cut <= (reason != des_pkg::R_KEEP);
      out_reason <= reason;
      out_energy <= q_data.is_empty ? '0 : q_data.energy_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      band_low <= '0;
      band_mid <= '0;
      band_high <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (take && !q_data.is_empty) begin
        if (in_low && band_low != des_pkg::BAND_SAT) begin
          band_low <= band_low + des_pkg::BAND_W'(1);
        end
        if (in_mid && band_mid != des_pkg::BAND_SAT) begin
          band_mid <= band_mid + des_pkg::BAND_W'(1);
        end
        if (in_high && band_high != des_pkg::BAND_SAT) begin
          band_high <= band_high + des_pkg::BAND_W'(1);
        end
      end
    end
  end

  a_cut_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cut == (out_reason != des_pkg::R_KEEP)))
    else $error("cut flag disagrees with reason");

  a_empty_zero_energy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reason == des_pkg::R_EMPTY) |-> (out_energy == '0))
    else $error("empty event with nonzero energy");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("taken word not presented");

  a_bands_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> $stable(band_low) && $stable(band_mid) && $stable(band_high))
    else $error("band counts changed under a waiting word");

endmodule
`default_nettype wire

// ===== sv/detector_event_selector.sv =====
// detector event selector
// input channel: push / full. one hit word per accepted push; last_hit marks the
// final hit of an event, empty_event stands for an event with no hits.
// result channel: empty / pop. one word per finished event, oldest first, held
// on the result ports while empty is low and taken by pop.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, write only while no event is in flight.
// throughput: one hit per cycle, sustained, while results are drained.
// path: the summary of an event is written into the summary queue by the edge that
// takes its last hit, then moves into the decision register that drives the result ports.
// a two-entry summary queue sits between accumulation and decision.
// when pop is held low the result register and then the queue fill, and full
// rises; non-final hits are also held off until a summary slot frees up.
// reset: config returns to its defaults, band counters and the partial event
// clear, the summary queue and the result register empty; no clearing pass.
`default_nettype none
module detector_event_selector (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  empty_event,
  input  logic                                  telescope_id,
  input  logic [3:0]                            detector_id,
  input  logic [des_pkg::HIT_E_W-1:0]           hit_energy_ev,
  input  logic signed [des_pkg::Z_W-1:0]        hit_z_um,
  input  logic                                  bad_depth_cal,
  input  logic                                  depth_cut_mark,
  input  logic                                  last_hit,
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  event_cut,
  output logic [2:0]                            cut_reason,
  output logic [des_pkg::ENERGY_W-1:0]          total_energy_ev,
  output logic [des_pkg::BAND_W-1:0]            band_low_count,
  output logic [des_pkg::BAND_W-1:0]            band_mid_count,
  output logic [des_pkg::BAND_W-1:0]            band_high_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [des_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [des_pkg::CFG_DATA_W-1:0]        cfg_data
);

  des_pkg::cfg_t     cfg;
  des_pkg::summary_t sum_wr;
  des_pkg::summary_t sum_rd;
  logic              sum_push;
  logic              q_full;
  logic              q_valid;
  logic              q_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.energy_min_ev <= des_pkg::ENERGY_MIN_RST;
      cfg.energy_max_ev <= des_pkg::ENERGY_MAX_RST;
      cfg.depth_max_um <= des_pkg::DEPTH_MAX_RST;
      cfg.half_height_um <= des_pkg::HALF_HEIGHT_RST;
      cfg.cut_bad_depth_cal <= 1'b0;
      cfg.cut_depth_flag <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        des_pkg::CFG_ENERGY_MIN: begin
          cfg.energy_min_ev <= cfg_data[des_pkg::ENERGY_W-1:0];
        end
        des_pkg::CFG_ENERGY_MAX: begin
          cfg.energy_max_ev <= cfg_data[des_pkg::ENERGY_W-1:0];
        end
        des_pkg::CFG_DEPTH_MAX: begin
          cfg.depth_max_um <= cfg_data[des_pkg::DEPTH_MAX_W-1:0];
        end
        des_pkg::CFG_HALF_HEIGHT: begin
          cfg.half_height_um <= cfg_data[des_pkg::HALF_W-1:0];
        end
        des_pkg::CFG_CUT_BAD_CAL: begin
          cfg.cut_bad_depth_cal <= cfg_data[0];
        end
        des_pkg::CFG_CUT_DEPTH_FLAG: begin
          cfg.cut_depth_flag <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  des_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .push           (push),
    .full           (full),
    .empty_event    (empty_event),
    .telescope_id   (telescope_id),
    .detector_id    (detector_id),
    .hit_energy_ev  (hit_energy_ev),
    .hit_z_um       (hit_z_um),
    .bad_depth_cal  (bad_depth_cal),
    .depth_cut_mark (depth_cut_mark),
    .last_hit       (last_hit),
    .q_full         (q_full),
    .sum_push       (sum_push),
    .sum_data       (sum_wr)
  );

  des_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (sum_push),
    .wr_data (sum_wr),
    .full    (q_full),
    .rd_en   (q_rd),
    .valid   (q_valid),
    .rd_data (sum_rd)
  );

  des_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_data          (sum_rd),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .event_cut       (event_cut),
    .cut_reason      (cut_reason),
    .total_energy_ev (total_energy_ev),
    .band_low_count  (band_low_count),
    .band_mid_count  (band_mid_count),
    .band_high_count (band_high_count)
  );

endmodule
`default_nettype wire
